[design/sorted_interval_set_merge_unit_defines.svh]
// assertion macros shared by the interval set merge unit
// each macro expects clk and rst_n in scope
`ifndef SORTED_INTERVAL_SET_MERGE_UNIT_DEFINES_SVH
`define SORTED_INTERVAL_SET_MERGE_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define SISM_ASSERT_HOLDS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequence holds in the same cycle as the antecedent
`define SISM_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define SISM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sism_pkg.sv]
`default_nettype none

package sism_pkg;

    // table size and value width
    localparam int MAX_INTERVALS = 32;
    localparam int VALUE_BITS    = 32;
    localparam int DATA_W        = 32;
    localparam int STATUS_W      = 3;
    localparam int IDX_W         = $clog2(MAX_INTERVALS);
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
    localparam int ENTRY_W       = 2 * VALUE_BITS;
    localparam int PC_W          = 5;

    typedef logic [CNT_W-1:0]             cnt_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic signed [VALUE_BITS-1:0] val_t;
    typedef logic signed [VALUE_BITS:0]   ext_t;
    typedef logic signed [DATA_W-1:0]     data_t;
    typedef logic [ENTRY_W-1:0]           entry_t;
    typedef logic [STATUS_W-1:0]          status_t;
    typedef logic [PC_W-1:0]              pc_t;

    // result status codes
    localparam status_t ST_NEW      = status_t'(0);
    localparam status_t ST_EXTENDED = status_t'(1);
    localparam status_t ST_JOINED   = status_t'(2);
    localparam status_t ST_COVERED  = status_t'(3);
    localparam status_t ST_FULL     = status_t'(4);
    localparam status_t ST_LIST     = status_t'(5);

    // datapath operations, one per control word
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ_IDX,
        OP_CMP,
        OP_PTR_CNT,
        OP_READ_PM1,
        OP_SHIFT_UP,
        OP_WR_NEW,
        OP_WR_LO,
        OP_WR_HI,
        OP_WR_JOIN,
        OP_READ_PP1,
        OP_SHIFT_DN,
        OP_DEC_CNT,
        OP_SET_COV,
        OP_SET_FULL,
        OP_EMIT_ADD,
        OP_EMIT_LIST,
        OP_EMIT_EMPTY
    } op_t;

    // jump conditions
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IN_LIST,
        COND_RD_LE,
        COND_AT_END,
        COND_COVERED,
        COND_JOIN,
        COND_TOUCH_LO,
        COND_TOUCH_HI,
        COND_FULL,
        COND_PTR_IS_IDX,
        COND_PTR1_IS_CNT,
        COND_CNT_ZERO,
        COND_LIST_MORE
    } cond_t;

    // handshake a step waits for before it executes
    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_IN,
        WAIT_OUT
    } wait_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        wait_t wait_on;
        pc_t   target;
    } ctrl_word_t;

    // sequencer to datapath
    typedef struct packed {
        op_t  op;
        logic take_in;
    } ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic in_list;
        logic rd_le;
        logic at_end;
        logic covered;
        logic joins;
        logic touch_lo;
        logic touch_hi;
        logic full;
        logic ptr_is_idx;
        logic ptr1_is_cnt;
        logic cnt_zero;
        logic list_more;
    } flags_t;

    // microprogram addresses
    localparam pc_t STEP_IDLE    = pc_t'(0);
    localparam pc_t STEP_A_RD    = pc_t'(1);
    localparam pc_t STEP_A_CMP   = pc_t'(2);
    localparam pc_t STEP_A_COV   = pc_t'(3);
    localparam pc_t STEP_A_JOIN  = pc_t'(4);
    localparam pc_t STEP_A_LO    = pc_t'(5);
    localparam pc_t STEP_A_HI    = pc_t'(6);
    localparam pc_t STEP_A_FULL  = pc_t'(7);
    localparam pc_t STEP_N_INIT  = pc_t'(8);
    localparam pc_t STEP_N_RD    = pc_t'(9);
    localparam pc_t STEP_N_SH    = pc_t'(10);
    localparam pc_t STEP_N_NEW   = pc_t'(11);
    localparam pc_t STEP_X_LO    = pc_t'(12);
    localparam pc_t STEP_X_HI    = pc_t'(13);
    localparam pc_t STEP_J_WR    = pc_t'(14);
    localparam pc_t STEP_J_RD    = pc_t'(15);
    localparam pc_t STEP_J_SH    = pc_t'(16);
    localparam pc_t STEP_J_END   = pc_t'(17);
    localparam pc_t STEP_E_COV   = pc_t'(18);
    localparam pc_t STEP_E_FULL  = pc_t'(19);
    localparam pc_t STEP_EMIT    = pc_t'(20);
    localparam pc_t STEP_L_CHK   = pc_t'(21);
    localparam pc_t STEP_L_RD    = pc_t'(22);
    localparam pc_t STEP_L_EM    = pc_t'(23);
    localparam pc_t STEP_L_DONE  = pc_t'(24);
    localparam pc_t STEP_L_EMPTY = pc_t'(25);

    // control store: a jump is taken when its condition holds, else pc + 1
    function automatic ctrl_word_t rom_word(input pc_t pc);
        ctrl_word_t w;
        w = '{OP_NONE, COND_ALWAYS, WAIT_NONE, STEP_IDLE};
        unique case (pc)
            STEP_IDLE:    w = '{OP_LOAD,       COND_IN_LIST,     WAIT_IN,   STEP_L_CHK};
            STEP_A_RD:    w = '{OP_READ_IDX,   COND_AT_END,      WAIT_NONE, STEP_A_COV};
            STEP_A_CMP:   w = '{OP_CMP,        COND_RD_LE,       WAIT_NONE, STEP_A_RD};
            STEP_A_COV:   w = '{OP_NONE,       COND_COVERED,     WAIT_NONE, STEP_E_COV};
            STEP_A_JOIN:  w = '{OP_NONE,       COND_JOIN,        WAIT_NONE, STEP_J_WR};
            STEP_A_LO:    w = '{OP_NONE,       COND_TOUCH_LO,    WAIT_NONE, STEP_X_LO};
            STEP_A_HI:    w = '{OP_NONE,       COND_TOUCH_HI,    WAIT_NONE, STEP_X_HI};
            STEP_A_FULL:  w = '{OP_NONE,       COND_FULL,        WAIT_NONE, STEP_E_FULL};
            STEP_N_INIT:  w = '{OP_PTR_CNT,    COND_NEVER,       WAIT_NONE, STEP_IDLE};
            STEP_N_RD:    w = '{OP_READ_PM1,   COND_PTR_IS_IDX,  WAIT_NONE, STEP_N_NEW};
            STEP_N_SH:    w = '{OP_SHIFT_UP,   COND_ALWAYS,      WAIT_NONE, STEP_N_RD};
            STEP_N_NEW:   w = '{OP_WR_NEW,     COND_ALWAYS,      WAIT_NONE, STEP_EMIT};
            STEP_X_LO:    w = '{OP_WR_LO,      COND_ALWAYS,      WAIT_NONE, STEP_EMIT};
            STEP_X_HI:    w = '{OP_WR_HI,      COND_ALWAYS,      WAIT_NONE, STEP_EMIT};
            STEP_J_WR:    w = '{OP_WR_JOIN,    COND_NEVER,       WAIT_NONE, STEP_IDLE};
            STEP_J_RD:    w = '{OP_READ_PP1,   COND_PTR1_IS_CNT, WAIT_NONE, STEP_J_END};
            STEP_J_SH:    w = '{OP_SHIFT_DN,   COND_ALWAYS,      WAIT_NONE, STEP_J_RD};
            STEP_J_END:   w = '{OP_DEC_CNT,    COND_ALWAYS,      WAIT_NONE, STEP_EMIT};
            STEP_E_COV:   w = '{OP_SET_COV,    COND_ALWAYS,      WAIT_NONE, STEP_EMIT};
            STEP_E_FULL:  w = '{OP_SET_FULL,   COND_ALWAYS,      WAIT_NONE, STEP_EMIT};
            STEP_EMIT:    w = '{OP_EMIT_ADD,   COND_ALWAYS,      WAIT_OUT,  STEP_IDLE};
            STEP_L_CHK:   w = '{OP_NONE,       COND_CNT_ZERO,    WAIT_NONE, STEP_L_EMPTY};
            STEP_L_RD:    w = '{OP_READ_IDX,   COND_NEVER,       WAIT_NONE, STEP_IDLE};
            STEP_L_EM:    w = '{OP_EMIT_LIST,  COND_LIST_MORE,   WAIT_OUT,  STEP_L_RD};
            STEP_L_DONE:  w = '{OP_NONE,       COND_ALWAYS,      WAIT_NONE, STEP_IDLE};
            STEP_L_EMPTY: w = '{OP_EMIT_EMPTY, COND_ALWAYS,      WAIT_OUT,  STEP_IDLE};
            default:      w = '{OP_NONE,       COND_ALWAYS,      WAIT_NONE, STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[design/sism_ram.sv]
`default_nettype none

module sism_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 64,
    parameter int AW    = 5
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // one registered read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/sism_seq.sv]
`default_nettype none

module sism_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sism_pkg::flags_t flags,
    output sism_pkg::ctrl_t       ctrl
);

    sism_pkg::pc_t        pc_reg;
    sism_pkg::pc_t        pc_next;
    sism_pkg::ctrl_word_t word;
    logic                 go;
    logic                 cond_hit;

    // fetch the control word
    assign word = sism_pkg::rom_word(pc_reg);

    // a step executes once its handshake is available
    always_comb
    begin
        unique case (word.wait_on)
            sism_pkg::WAIT_IN:  go = flags.in_valid;
            sism_pkg::WAIT_OUT: go = flags.out_free;
            default:            go = 1'b1;
        endcase
    end

    // jump condition select
    always_comb
    begin
        unique case (word.cond)
            sism_pkg::COND_NEVER:       cond_hit = 1'b0;
            sism_pkg::COND_ALWAYS:      cond_hit = 1'b1;
            sism_pkg::COND_IN_LIST:     cond_hit = flags.in_list;
            sism_pkg::COND_RD_LE:       cond_hit = flags.rd_le;
            sism_pkg::COND_AT_END:      cond_hit = flags.at_end;
            sism_pkg::COND_COVERED:     cond_hit = flags.covered;
            sism_pkg::COND_JOIN:        cond_hit = flags.joins;
            sism_pkg::COND_TOUCH_LO:    cond_hit = flags.touch_lo;
            sism_pkg::COND_TOUCH_HI:    cond_hit = flags.touch_hi;
            sism_pkg::COND_FULL:        cond_hit = flags.full;
            sism_pkg::COND_PTR_IS_IDX:  cond_hit = flags.ptr_is_idx;
            sism_pkg::COND_PTR1_IS_CNT: cond_hit = flags.ptr1_is_cnt;
            sism_pkg::COND_CNT_ZERO:    cond_hit = flags.cnt_zero;
            sism_pkg::COND_LIST_MORE:   cond_hit = flags.list_more;
            default:                    cond_hit = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        priority if (!go)
        begin
            pc_next = pc_reg;
        end
        else if (cond_hit)
        begin
            pc_next = word.target;
        end
        else
        begin
            pc_next = pc_reg + sism_pkg::pc_t'(1);
        end
    end

    // control to the datapath
    always_comb
    begin
        ctrl.op      = go ? word.op : sism_pkg::OP_NONE;
        ctrl.take_in = (word.wait_on == sism_pkg::WAIT_IN);
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= sism_pkg::STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

[design/sism_dp.sv]
`default_nettype none
`include "sorted_interval_set_merge_unit_defines.svh"

module sism_dp (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire sism_pkg::ctrl_t         ctrl,
    output sism_pkg::flags_t             flags,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    req_type,
    input  wire sism_pkg::data_t         add_value,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output sism_pkg::status_t            status,
    output sism_pkg::data_t              interval_start,
    output sism_pkg::data_t              interval_end,
    output logic                         list_empty,
    output logic                         last
);

    // control registers
    sism_pkg::cnt_t    cnt_reg, cnt_next;
    sism_pkg::cnt_t    idx_reg, idx_next;
    sism_pkg::cnt_t    ptr_reg, ptr_next;
    logic              out_valid_reg, out_valid_next;

    // working registers
    sism_pkg::val_t    val_reg, val_next;
    sism_pkg::val_t    lo_start_reg, lo_start_next;
    sism_pkg::val_t    lo_end_reg, lo_end_next;
    sism_pkg::val_t    hi_start_reg, hi_start_next;
    sism_pkg::val_t    hi_end_reg, hi_end_next;
    sism_pkg::status_t st_reg, st_next;

    // output registers
    sism_pkg::status_t out_status_reg, out_status_next;
    sism_pkg::data_t   out_start_reg, out_start_next;
    sism_pkg::data_t   out_end_reg, out_end_next;
    logic              out_empty_reg, out_empty_next;
    logic              out_last_reg, out_last_next;

    // table memory
    logic              ram_we;
    logic              ram_re;
    sism_pkg::idx_t    ram_waddr;
    sism_pkg::idx_t    ram_raddr;
    sism_pkg::entry_t  ram_wdata;
    sism_pkg::entry_t  ram_rdata;

    sism_pkg::val_t    rd_start;
    sism_pkg::val_t    rd_end;
    sism_pkg::ext_t    val_x;
    sism_pkg::cnt_t    idx_m1;
    sism_pkg::cnt_t    idx_p1;
    sism_pkg::cnt_t    ptr_m1;
    sism_pkg::cnt_t    ptr_p1;
    logic              has_low;
    logic              touch_lo;
    logic              touch_hi;
    logic              out_free;
    logic              emit;

    sism_ram #(
        .DEPTH (sism_pkg::MAX_INTERVALS),
        .WIDTH (sism_pkg::ENTRY_W),
        .AW    (sism_pkg::IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // entry fields and neighbor arithmetic
    assign rd_start = sism_pkg::val_t'(ram_rdata[sism_pkg::ENTRY_W-1:sism_pkg::VALUE_BITS]);
    assign rd_end   = sism_pkg::val_t'(ram_rdata[sism_pkg::VALUE_BITS-1:0]);
    assign val_x    = sism_pkg::ext_t'(val_reg);
    assign idx_m1   = idx_reg - sism_pkg::cnt_t'(1);
    assign idx_p1   = idx_reg + sism_pkg::cnt_t'(1);
    assign ptr_m1   = ptr_reg - sism_pkg::cnt_t'(1);
    assign ptr_p1   = ptr_reg + sism_pkg::cnt_t'(1);
    assign has_low  = (idx_reg != '0);
    assign touch_lo = has_low
        && (sism_pkg::ext_t'(lo_end_reg) + sism_pkg::ext_t'(1) == val_x);
    assign touch_hi = (idx_reg < cnt_reg)
        && (sism_pkg::ext_t'(hi_start_reg) - sism_pkg::ext_t'(1) == val_x);
    assign out_free = !out_valid_reg || !out_stall;

    // status flags for the sequencer
    always_comb
    begin
        flags.in_valid    = in_valid;
        flags.out_free    = out_free;
        flags.in_list     = req_type;
        flags.rd_le       = (rd_start <= val_reg);
        flags.at_end      = (idx_reg == cnt_reg);
        flags.covered     = has_low && (lo_end_reg >= val_reg);
        flags.joins       = touch_lo && touch_hi;
        flags.touch_lo    = touch_lo;
        flags.touch_hi    = touch_hi;
        flags.full        = (cnt_reg == sism_pkg::cnt_t'(sism_pkg::MAX_INTERVALS));
        flags.ptr_is_idx  = (ptr_reg == idx_reg);
        flags.ptr1_is_cnt = (ptr_p1 == cnt_reg);
        flags.cnt_zero    = (cnt_reg == '0);
        flags.list_more   = (idx_p1 != cnt_reg);
    end

    // memory port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = idx_reg[sism_pkg::IDX_W-1:0];
        ram_raddr = idx_reg[sism_pkg::IDX_W-1:0];
        ram_wdata = {val_reg, val_reg};
        unique case (ctrl.op)
            sism_pkg::OP_READ_IDX:
            begin
                ram_re = 1'b1;
            end
            sism_pkg::OP_READ_PM1:
            begin
                ram_re    = 1'b1;
                ram_raddr = ptr_m1[sism_pkg::IDX_W-1:0];
            end
            sism_pkg::OP_READ_PP1:
            begin
                ram_re    = 1'b1;
                ram_raddr = ptr_p1[sism_pkg::IDX_W-1:0];
            end
            sism_pkg::OP_SHIFT_UP,
            sism_pkg::OP_SHIFT_DN:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[sism_pkg::IDX_W-1:0];
                ram_wdata = ram_rdata;
            end
            sism_pkg::OP_WR_NEW:
            begin
                ram_we = 1'b1;
            end
            sism_pkg::OP_WR_LO:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_m1[sism_pkg::IDX_W-1:0];
                ram_wdata = {lo_start_reg, val_reg};
            end
            sism_pkg::OP_WR_HI:
            begin
                ram_we    = 1'b1;
                ram_wdata = {val_reg, hi_end_reg};
            end
            sism_pkg::OP_WR_JOIN:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_m1[sism_pkg::IDX_W-1:0];
                ram_wdata = {lo_start_reg, hi_end_reg};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // register updates per operation
    always_comb
    begin
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        ptr_next        = ptr_reg;
        val_next        = val_reg;
        lo_start_next   = lo_start_reg;
        lo_end_next     = lo_end_reg;
        hi_start_next   = hi_start_reg;
        hi_end_next     = hi_end_reg;
        st_next         = st_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        out_empty_next  = out_empty_reg;
        out_last_next   = out_last_reg;
        emit            = 1'b0;
        unique case (ctrl.op)
            sism_pkg::OP_LOAD:
            begin
                val_next = sism_pkg::val_t'(add_value);
                idx_next = '0;
            end
            sism_pkg::OP_CMP:
            begin
                if (rd_start <= val_reg)
                begin
                    lo_start_next = rd_start;
                    lo_end_next   = rd_end;
                    idx_next      = idx_p1;
                end
                else
                begin
                    hi_start_next = rd_start;
                    hi_end_next   = rd_end;
                end
            end
            sism_pkg::OP_PTR_CNT:
            begin
                ptr_next = cnt_reg;
            end
            sism_pkg::OP_SHIFT_UP:
            begin
                ptr_next = ptr_m1;
            end
            sism_pkg::OP_SHIFT_DN:
            begin
                ptr_next = ptr_p1;
            end
            sism_pkg::OP_WR_NEW:
            begin
                cnt_next = cnt_reg + sism_pkg::cnt_t'(1);
                st_next  = sism_pkg::ST_NEW;
            end
            sism_pkg::OP_WR_LO,
            sism_pkg::OP_WR_HI:
            begin
                st_next = sism_pkg::ST_EXTENDED;
            end
            sism_pkg::OP_WR_JOIN:
            begin
                st_next  = sism_pkg::ST_JOINED;
                ptr_next = idx_reg;
            end
            sism_pkg::OP_DEC_CNT:
            begin
                cnt_next = cnt_reg - sism_pkg::cnt_t'(1);
            end
            sism_pkg::OP_SET_COV:
            begin
                st_next = sism_pkg::ST_COVERED;
            end
            sism_pkg::OP_SET_FULL:
            begin
                st_next = sism_pkg::ST_FULL;
            end
            sism_pkg::OP_EMIT_ADD:
            begin
                emit            = 1'b1;
                out_status_next = st_reg;
                out_start_next  = '0;
                out_end_next    = '0;
                out_empty_next  = 1'b0;
                out_last_next   = 1'b1;
            end
            sism_pkg::OP_EMIT_LIST:
            begin
                emit            = 1'b1;
                out_status_next = sism_pkg::ST_LIST;
                out_start_next  = sism_pkg::data_t'(rd_start);
                out_end_next    = sism_pkg::data_t'(rd_end);
                out_empty_next  = 1'b0;
                out_last_next   = (idx_p1 == cnt_reg);
                idx_next        = idx_p1;
            end
            sism_pkg::OP_EMIT_EMPTY:
            begin
                emit            = 1'b1;
                out_status_next = sism_pkg::ST_LIST;
                out_start_next  = '0;
                out_end_next    = '0;
                out_empty_next  = 1'b1;
                out_last_next   = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        out_valid_next = emit || (out_valid_reg && out_stall);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        val_reg        <= val_next;
        lo_start_reg   <= lo_start_next;
        lo_end_reg     <= lo_end_next;
        hi_start_reg   <= hi_start_next;
        hi_end_reg     <= hi_end_next;
        st_reg         <= st_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_end_reg    <= out_end_next;
        out_empty_reg  <= out_empty_next;
        out_last_reg   <= out_last_next;
    end

    // ports
    assign in_stall       = !ctrl.take_in;
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign interval_start = out_start_reg;
    assign interval_end   = out_end_reg;
    assign list_empty     = out_empty_reg;
    assign last           = out_last_reg;

    // checks
    `SISM_ASSERT_HOLDS(a_cnt_bound, cnt_reg <= sism_pkg::cnt_t'(sism_pkg::MAX_INTERVALS), "interval count above table size")
    `SISM_ASSERT_IMPLIES(a_new_room, ctrl.op == sism_pkg::OP_WR_NEW, cnt_reg < sism_pkg::cnt_t'(sism_pkg::MAX_INTERVALS), "new interval written into a full table")
    `SISM_ASSERT_IMPLIES(a_join_span, ctrl.op == sism_pkg::OP_WR_JOIN, has_low && (idx_reg < cnt_reg), "join without two neighbors")
    `SISM_ASSERT_NEXT(a_join_shrinks, ctrl.op == sism_pkg::OP_DEC_CNT, cnt_reg == $past(cnt_reg) - sism_pkg::cnt_t'(1), "join did not drop one interval")
    `SISM_ASSERT_IMPLIES(a_emit_free, emit, !(out_valid_reg && out_stall), "pending item overwritten")

endmodule

`default_nettype wire

[design/sorted_interval_set_merge_unit.sv]
// Sorted interval set merge unit.
// Input channel (in_valid / in_stall): req_type 0 adds add_value to the set of
// disjoint, non-adjacent intervals; req_type 1 lists every stored interval.
// Output channel (out_valid / out_stall): an add gives one item with status
// new, extended, joined, covered or full, and last set. A list gives one item
// per interval in ascending order, last on the final one, or a single item
// with list_empty set when the table is empty.
// One item is processed at a time by a microcoded sequencer; in_stall is low
// only while the sequencer sits at its idle step. Timing is set by the single
// table memory (one write and one registered read per cycle). An add scans
// the table upward until the end or the first entry starting above the value,
// then checks for covered, join, extend and full in that order; opening a new
// entry moves every entry above it up by one and joining two moves the
// entries above the joined pair down by one. A list reads and emits each
// entry in turn. Results wait in an output register; while a result is still
// held and out_stall is high, the sequencer holds at its next emit step and
// takes no new item.
// Reset clears the interval count and the sequencer; the table needs no
// clearing pass since only entries below the count are ever used.
`default_nettype none

module sorted_interval_set_merge_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              req_type,
    input  wire sism_pkg::data_t   add_value,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output sism_pkg::status_t      status,
    output sism_pkg::data_t        interval_start,
    output sism_pkg::data_t        interval_end,
    output logic                   list_empty,
    output logic                   last
);

    sism_pkg::ctrl_t  ctrl;
    sism_pkg::flags_t flags;

    // microprogram sequencer
    sism_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // table datapath and output register
    sism_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .flags          (flags),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .add_value      (add_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .interval_start (interval_start),
        .interval_end   (interval_end),
        .list_empty     (list_empty),
        .last           (last)
    );

endmodule

`default_nettype wire

[dv/sorted_interval_set_merge_unit_tb.sv]
`default_nettype none

module sorted_interval_set_merge_unit_tb;

    // request kinds on req_type
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_LIST = 1'b1;

    localparam int     IDLE_LIMIT  = 3000;
    localparam int     HOLD_CYCLES = 300;
    localparam int     PHASE_ITEMS = 55;
    localparam int     MAX_REPORTS = 10;
    localparam longint VAL_MAX     = 64'sd2147483647;
    localparam longint VAL_MIN     = -64'sd2147483648;

    typedef struct {
        logic            kind;
        sism_pkg::data_t value;
    } request_t;

    typedef struct {
        sism_pkg::status_t st;
        sism_pkg::data_t   lo;
        sism_pkg::data_t   hi;
        logic              empty;
        logic              fin;
    } result_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              req_type  = REQ_ADD;
    sism_pkg::data_t   add_value = '0;
    logic              out_stall = 1'b0;
    logic              in_stall;
    logic              out_valid;
    sism_pkg::status_t status;
    sism_pkg::data_t   interval_start;
    sism_pkg::data_t   interval_end;
    logic              list_empty;
    logic              last;

    request_t pending_requests[$];
    result_t  due_results[$];
    result_t  head;

    // shadow copy of the interval table
    longint span_lo [sism_pkg::MAX_INTERVALS];
    longint span_hi [sism_pkg::MAX_INTERVALS];
    int     span_count = 0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_request  = 1'b0;
    int hold_count    = 0;
    int queued_items  = 0;
    int fault_count   = 0;
    int idle_run      = 0;

    sorted_interval_set_merge_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .add_value      (add_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .interval_start (interval_start),
        .interval_end   (interval_end),
        .list_empty     (list_empty),
        .last           (last)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // append one predicted result
    function automatic void queue_result(input result_t r);
        due_results.insert(due_results.size(), r);
    endfunction

    // work out the results one request causes and update the shadow table
    function automatic void predict_results(input logic kind, input sism_pkg::data_t raw);
        longint            v;
        int                pos;
        int                k;
        logic              below;
        logic              meets_lo;
        logic              meets_hi;
        sism_pkg::status_t st;
        if (kind == REQ_LIST)
        begin
            if (span_count == 0)
                queue_result(result_t'{sism_pkg::ST_LIST, '0, '0, 1'b1, 1'b1});
            else
                for (k = 0; k < span_count; k++)
                    queue_result(result_t'{sism_pkg::ST_LIST,
                        sism_pkg::data_t'(span_lo[k]), sism_pkg::data_t'(span_hi[k]),
                        1'b0, logic'(k == span_count - 1)});
            return;
        end
        v = longint'(sism_pkg::val_t'(raw));
        pos = 0;
        while (pos < span_count && span_lo[pos] <= v)
            pos++;
        below = pos > 0;
        meets_lo = 1'b0;
        meets_hi = 1'b0;
        if (below)
            meets_lo = (span_hi[pos-1] + 1 == v);
        if (pos < span_count)
            meets_hi = (span_lo[pos] - 1 == v);
        if (below && span_hi[pos-1] >= v)
            st = sism_pkg::ST_COVERED;
        else if (meets_lo && meets_hi)
        begin
            // bridge two neighbors, close the gap above
            span_hi[pos-1] = span_hi[pos];
            for (k = pos; k + 1 < span_count; k++)
            begin
                span_lo[k] = span_lo[k+1];
                span_hi[k] = span_hi[k+1];
            end
            span_count--;
            st = sism_pkg::ST_JOINED;
        end
        else if (meets_lo)
        begin
            span_hi[pos-1] = v;
            st = sism_pkg::ST_EXTENDED;
        end
        else if (meets_hi)
        begin
            span_lo[pos] = v;
            st = sism_pkg::ST_EXTENDED;
        end
        else if (span_count >= sism_pkg::MAX_INTERVALS)
            st = sism_pkg::ST_FULL;
        else
        begin
            // open a new single-value entry
            for (k = span_count; k > pos; k--)
            begin
                span_lo[k] = span_lo[k-1];
                span_hi[k] = span_hi[k-1];
            end
            span_lo[pos] = v;
            span_hi[pos] = v;
            span_count++;
            st = sism_pkg::ST_NEW;
        end
        queue_result(result_t'{st, '0, '0, 1'b0, 1'b1});
    endfunction

    function automatic void report_fault(input string why, input result_t want);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display({"mismatch (%s): expected st=%0d lo=%0d hi=%0d empty=%b last=%b,",
                " got st=%0d lo=%0d hi=%0d empty=%b last=%b"},
                why, want.st, want.lo, want.hi, want.empty, want.fin,
                status, interval_start, interval_end, list_empty, last);
    endfunction

    task automatic push_request(input logic kind, input longint v);
        pending_requests.insert(pending_requests.size(),
            request_t'{kind, sism_pkg::data_t'(v)});
        queued_items++;
    endtask

    // spaced singletons that overflow the table, then the gaps between them
    task automatic queue_fill_episode();
        longint b;
        int     k;
        int     pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            b = VAL_MIN + $urandom_range(0, 2);
        else if (pick == 1)
            b = VAL_MAX - 99 - $urandom_range(0, 2);
        else
        begin
            b = longint'($signed($urandom));
            if (b > VAL_MAX - 120)
                b = b - 200;
        end
        if ($urandom_range(0, 1) == 1)
            for (k = 0; k < 34; k++)
                push_request(REQ_ADD, b + 3 * k);
        else
            for (k = 33; k >= 0; k--)
                push_request(REQ_ADD, b + 3 * k);
        push_request(REQ_LIST, longint'($signed($urandom)));
        for (k = 0; k < 20; k++)
            push_request(REQ_ADD, b + 3 * $urandom_range(0, 32) + $urandom_range(1, 2));
        push_request(REQ_LIST, longint'($signed($urandom)));
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
    endtask

    // driver: offer queued requests, hold each until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            req_type  <= REQ_ADD;
            add_value <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid  <= 1'b1;
                req_type  <= pending_requests[0].kind;
                add_value <= pending_requests[0].value;
                void'(pending_requests.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: one long hold-off on request, random stalls otherwise
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            hold_count <= 0;
        end
        else if (hold_request && hold_count < HOLD_CYCLES)
        begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // monitor: check delivered results, predict accepted requests
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                    report_fault("unexpected result", result_t'{'0, '0, '0, 1'b0, 1'b0});
                else
                begin
                    head = due_results.pop_front();
                    if (status !== head.st || interval_start !== head.lo
                        || interval_end !== head.hi || list_empty !== head.empty
                        || last !== head.fin)
                        report_fault("field", head);
                end
            end
            if (in_valid && !in_stall)
                predict_results(req_type, add_value);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_run <= 0;
            else if (idle_run >= IDLE_LIMIT)
            begin
                $display("FAIL sorted_interval_set_merge_unit");
                $finish;
            end
            else
                idle_run <= idle_run + 1;
        end
    end

    // stimulus
    initial
    begin
        int     phase;
        int     mark;
        int     pick;
        int     k;
        longint anchors [4];
        longint a;
        anchors = '{VAL_MIN, -20, 5000, VAL_MAX - 40};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty list, every status but full, value extremes, joins
        push_request(REQ_LIST, 0);
        push_request(REQ_ADD, 0);
        push_request(REQ_ADD, 0);
        push_request(REQ_ADD, 1);
        push_request(REQ_ADD, -1);
        push_request(REQ_ADD, 3);
        push_request(REQ_ADD, 2);
        push_request(REQ_ADD, VAL_MAX);
        push_request(REQ_ADD, VAL_MIN);
        push_request(REQ_ADD, VAL_MAX - 1);
        push_request(REQ_ADD, VAL_MIN + 1);
        push_request(REQ_ADD, 5);
        push_request(REQ_ADD, 7);
        push_request(REQ_ADD, 6);
        push_request(REQ_LIST, -1);
        push_request(REQ_ADD, -5);
        push_request(REQ_ADD, -3);
        push_request(REQ_ADD, -4);
        push_request(REQ_ADD, -2);
        push_request(REQ_LIST, VAL_MIN);

        for (phase = 0; phase < 5; phase++)
        begin
            wait_drained();
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 86; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 86; end
                3: begin send_idle_pct = 24; stall_pct = 24; end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    hold_request  = 1'b1;
                end
            endcase
            mark = queued_items;
            if (phase == 0)
                queue_fill_episode();
            while (queued_items - mark < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    queue_fill_episode();
                else if (pick < 70)
                begin
                    // dense adds around one anchor, then a listing
                    a = anchors[$urandom_range(0, 3)];
                    for (k = 0; k < 12; k++)
                        push_request(REQ_ADD, a + $urandom_range(0, 40));
                    push_request(REQ_LIST, longint'($signed($urandom)));
                end
                else
                begin
                    // scattered values, extremes and stray listings
                    for (k = 0; k < 6; k++)
                    begin
                        case ($urandom_range(0, 5))
                            0: push_request(REQ_LIST, longint'($signed($urandom)));
                            1: push_request(REQ_ADD, VAL_MAX - $urandom_range(0, 2));
                            2: push_request(REQ_ADD, VAL_MIN + $urandom_range(0, 2));
                            default: push_request(REQ_ADD, longint'($signed($urandom)));
                        endcase
                    end
                end
            end
        end
        wait_drained();
        repeat (150) @(negedge clk);

        if (fault_count == 0 && due_results.size() == 0)
            $display("PASS sorted_interval_set_merge_unit");
        else
            $display("FAIL sorted_interval_set_merge_unit");
        $finish;
    end

endmodule

`default_nettype wire

[sorted_interval_set_merge_unit.f]
+incdir+design
design/sism_pkg.sv
design/sism_ram.sv
design/sism_seq.sv
design/sism_dp.sv
design/sorted_interval_set_merge_unit.sv
dv/sorted_interval_set_merge_unit_tb.sv
